// ===== rtl/srod_pkg.sv =====
// ----------------------------------------------------------------------------
// srod_pkg
// Shared types and constants for the scan run object detector.
// ----------------------------------------------------------------------------
package srod_pkg;

	localparam int MAX_OBJECTS = 6;
	localparam int CNT_W       = $clog2(MAX_OBJECTS + 1);

	localparam int ANGLE_W = 8;
	localparam int RANGE_W = 8;
	localparam int OBJ_W   = 3;
	localparam int WIDTH_W = 8;
	localparam int SUM_W   = 16;
	localparam int SMALL_W = 16;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int DIV_STEPS = SUM_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam logic [RANGE_W-1:0] NEAR_LIMIT_RST  = 8'd80;
	localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST   = 8'd5;
	localparam logic [SMALL_W-1:0] SMALL_LIMIT_RST = 16'd460;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_NEAR_LIMIT  = 2'd0,
		CFG_MIN_WIDTH   = 2'd1,
		CFG_SMALL_LIMIT = 2'd2,
		CFG_UNUSED      = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_PROD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic div_start;
		logic div_step;
		logic prod;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic report;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/scan_run_object_detector_top.sv =====
// ----------------------------------------------------------------------------
// scan_run_object_detector_top
// Groups near range samples of a sweep into runs and reports wide runs.
//
// Channel  Dir  Handshake          Content
// s_*      in   s_tvalid/s_tready  one range sample per sweep angle
// m_*      out  m_tvalid/m_tready  one object report per reported run
// cfg_*    in   cfg_valid/cfg_ready  register index and write data
//
// A sample that reports nothing is only accepted. A reporting sample passes
// through accept, 16 steps of the restoring divider, the multiply and
// compare, and the output register load, which waits for a free register.
// The output register frees the input side while a report waits.
// Reset restores register defaults and clears the run and object count.
// ----------------------------------------------------------------------------
module scan_run_object_detector_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [srod_pkg::IN_DATA_W-1:0]       s_tdata,   // scan_angle, range_cm
	input  logic                                 s_tuser,   // sweep_start
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [srod_pkg::OUT_DATA_W-1:0]      m_tdata,   // object_number, centre_angle,
	                                                        // mean_range, run_width
	output logic                                 m_tuser,   // small_object
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [srod_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [srod_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import srod_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	srod_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	srod_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

// ===== rtl/srod_ctrl.sv =====
// ----------------------------------------------------------------------------
// srod_ctrl
// Sequencer: accepts items, runs the divider, forms and hands off reports.
// ----------------------------------------------------------------------------
module srod_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  srod_pkg::status_t status,
	output srod_pkg::cmd_t    cmd
);
	import srod_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					if (status.report) begin
						cmd.div_start = 1'b1;
						state_d       = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_PROD;
				end
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				state_d  = ST_OUT;
			end
			ST_OUT: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/srod_dpath.sv =====
// ----------------------------------------------------------------------------
// srod_dpath
// Run tracking, configuration registers, restoring divider and output register.
// ----------------------------------------------------------------------------
module srod_dpath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [srod_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [srod_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [srod_pkg::IN_DATA_W-1:0]       s_tdata,
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [srod_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic                                 m_tuser,
	input  srod_pkg::cmd_t                       cmd,
	output srod_pkg::status_t                    status
);
	import srod_pkg::*;

	logic [RANGE_W-1:0] near_limit_q;
	logic [WIDTH_W-1:0] min_width_q;
	logic [SMALL_W-1:0] small_limit_q;

	logic [WIDTH_W-1:0] run_length_q;
	logic [SUM_W-1:0]   range_sum_q;
	logic [CNT_W-1:0]   objects_q;

	logic [WIDTH_W-1:0]   width_q;
	logic [ANGLE_W-1:0]   centre_q;
	logic [OBJ_W-1:0]     objnum_q;
	logic [WIDTH_W-1:0]   rem_q;
	logic [SUM_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [RANGE_W-1:0]   mean_q;
	logic                 small_q;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_user_q;

	logic [ANGLE_W-1:0] angle;
	logic [RANGE_W-1:0] range_in;
	logic [WIDTH_W-1:0] len0;
	logic [SUM_W-1:0]   sum0;
	logic [CNT_W-1:0]   cnt0;
	logic               is_near;
	logic [SUM_W:0]     sum_ext;
	logic [WIDTH_W-1:0] half;
	logic [WIDTH_W:0]   shifted;
	logic               ge;
	logic [RANGE_W-1:0] mean_sat;
	logic [SUM_W-1:0]   prod;

	assign angle    = s_tdata[ANGLE_W-1:0];
	assign range_in = s_tdata[ANGLE_W +: RANGE_W];
	assign len0     = s_tuser ? '0 : run_length_q;
	assign sum0     = s_tuser ? '0 : range_sum_q;
	assign cnt0     = s_tuser ? '0 : objects_q;
	assign is_near  = range_in < near_limit_q;
	assign sum_ext  = {1'b0, sum0} + {{(SUM_W + 1 - RANGE_W){1'b0}}, range_in};
	assign half     = len0 >> 1;

	assign status.report   = !is_near && (len0 != '0) && (len0 >= min_width_q) &&
	                         (cnt0 < CNT_W'(MAX_OBJECTS));
	assign status.div_last = div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1);
	assign status.out_free = !out_valid_q || m_tready;

	assign shifted  = {rem_q, quo_q[SUM_W-1]};
	assign ge       = shifted >= {1'b0, width_q};
	assign mean_sat = (|quo_q[SUM_W-1:RANGE_W]) ? '1 : quo_q[RANGE_W-1:0];
	assign prod     = mean_sat * width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_limit_q  <= NEAR_LIMIT_RST;
			min_width_q   <= MIN_WIDTH_RST;
			small_limit_q <= SMALL_LIMIT_RST;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_NEAR_LIMIT:  near_limit_q  <= cfg_data[RANGE_W-1:0];
				CFG_MIN_WIDTH:   min_width_q   <= cfg_data[WIDTH_W-1:0];
				CFG_SMALL_LIMIT: small_limit_q <= cfg_data[SMALL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_length_q <= '0;
			range_sum_q  <= '0;
			objects_q    <= '0;
		end else if (cmd.accept) begin
			if (is_near) begin
				run_length_q <= (&len0) ? len0 : len0 + 1'b1;
				range_sum_q  <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
				objects_q    <= cnt0;
			end else begin
				run_length_q <= '0;
				range_sum_q  <= '0;
				objects_q    <= status.report ? cnt0 + 1'b1 : cnt0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			width_q  <= len0;
			centre_q <= (angle >= half) ? angle - half : '0;
			objnum_q <= OBJ_W'(cnt0);
			rem_q    <= '0;
			quo_q    <= sum0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? WIDTH_W'(shifted - {1'b0, width_q}) : shifted[WIDTH_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
		if (cmd.prod) begin
			mean_q  <= mean_sat;
			small_q <= prod < small_limit_q;
		end
		if (cmd.load_out) begin
			out_data_q <= {{(OUT_DATA_W - OBJ_W - ANGLE_W - RANGE_W - WIDTH_W){1'b0}},
			               width_q, mean_q, centre_q, objnum_q};
			out_user_q <= small_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.div_start) begin
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

// ===== rtl/srod_chk.sv =====
// ----------------------------------------------------------------------------
// srod_chk
// Port-level checks on the detector's report stream.
// ----------------------------------------------------------------------------
module srod_chk (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [srod_pkg::OUT_DATA_W-1:0]      m_tdata,
	input logic                                 m_tuser
);
	import srod_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("report dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("report changed while stalled");

	a_width_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OBJ_W+ANGLE_W+RANGE_W +: WIDTH_W] != '0)
		else $error("report with empty run");

	a_obj_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 32'(m_tdata[OBJ_W-1:0]) < 32'(MAX_OBJECTS))
		else $error("object number beyond table");

endmodule

bind scan_run_object_detector_top srod_chk u_srod_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
